// File: hw/rtl/clipped_shape_fill_canvas_defines.svh
// Assertion helpers shared by the canvas RTL.
`ifndef CLIPPED_SHAPE_FILL_CANVAS_DEFINES_SVH
`define CLIPPED_SHAPE_FILL_CANVAS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSFC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("canvas assertion failed");

// Next-cycle implication, checked outside reset.
`define CSFC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("canvas assertion failed");

`endif

// File: hw/rtl/csfc_pkg.sv
package csfc_pkg;

   // Command codes of an input item.
   localparam logic [2:0] CMD_RECT    = 3'd0;
   localparam logic [2:0] CMD_UP      = 3'd1;
   localparam logic [2:0] CMD_DOWN    = 3'd2;
   localparam logic [2:0] CMD_DIAMOND = 3'd3;
   localparam logic [2:0] CMD_CLEAR   = 3'd4;
   localparam logic [2:0] CMD_READ    = 3'd5;

   // Configuration register indexes.
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   // Character that a cleared cell holds.
   localparam logic [7:0] BLANK_CELL = 8'd46;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] anchor_row;
      logic [7:0] anchor_col;
      logic [7:0] brush;
      logic [7:0] extent_rows;
      logic [7:0] extent;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
   } rsp_type;

endpackage

// File: hw/rtl/clipped_shape_fill_canvas.sv
// Clipped shape-fill character canvas. The block keeps a MAX_ROWS x MAX_COLS canvas of
// byte cells in one single-port synchronous memory and executes one command per item:
// rectangle, up triangle, down triangle and diamond fills with a brush byte, clear, and
// read of one cell. Every item returns exactly one result item; only a read returns cell
// data. Shapes are walked one horizontal span at a time: each span has one setup step
// and then one write per visible pixel, since the memory takes one write per cycle.
// Spans are clipped to the rows and columns in use before the walk, so dropped pixels
// cost nothing. A diamond with half distance d has 2d+1 spans, and a clear writes one
// cell per cycle. After reset the same sweep fills the canvas with '.' while req_stall
// stays high; configuration writes are taken during it. A new item is accepted while
// the previous result still waits in the output register. Change rows_in_use or
// cols_in_use only while the block is idle, and issue a clear afterwards.
`include "clipped_shape_fill_canvas_defines.svh"

module clipped_shape_fill_canvas
   import csfc_pkg::*;
#(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_we,
   input  logic    csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROWI_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COLI_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_SPAN      = 3'd2;
   localparam logic [2:0] ST_PIXEL     = 3'd3;
   localparam logic [2:0] ST_READ      = 3'd4;
   localparam logic [2:0] ST_READ_DATA = 3'd5;
   localparam logic [2:0] ST_RESP      = 3'd6;

   // Control state.
   logic [2:0]        st_ff, st_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              phase_ff, phase_in;
   logic [8:0]        i_ff, i_in;
   logic [8:0]        spans_ff, spans_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rows_ff, rows_in;
   logic [7:0]        cols_ff, cols_in;

   // Item payload and walk position.
   logic [2:0]        cmd_ff, cmd_in;
   logic signed [11:0] ar_ff, ar_in;
   logic signed [11:0] ac_ff, ac_in;
   logic [7:0]        brush_ff, brush_in;
   logic [7:0]        ext_ff, ext_in;
   logic signed [11:0] row_ff, row_in;
   logic signed [11:0] col_ff, col_in;
   logic signed [11:0] hi_ff, hi_in;
   logic              rd_ok_ff, rd_ok_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;

   // Canvas memory.
   logic [7:0]        canvas_mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic              mem_re;
   logic [7:0]        mem_wdata;

   // Clip limits and span geometry.
   logic signed [11:0] lim_rows, lim_cols;
   logic signed [11:0] i_s, n_s;
   logic signed [11:0] span_row, span_lo, span_hi;
   logic signed [11:0] lo_c, hi_c;
   logic              span_ok;
   logic              accept;

   assign accept    = req_valid && (st_ff == ST_IDLE);
   assign req_stall = (st_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Sizes above the canvas act as the canvas size.
   assign lim_rows = ({4'b0000, rows_ff} > 12'(MAX_ROWS)) ? $signed(12'(MAX_ROWS))
                                                           : $signed({4'b0000, rows_ff});
   assign lim_cols = ({4'b0000, cols_ff} > 12'(MAX_COLS)) ? $signed(12'(MAX_COLS))
                                                           : $signed({4'b0000, cols_ff});

   assign i_s = $signed({3'b000, i_ff});
   assign n_s = $signed({4'b0000, ext_ff});

   // Span i of the current shape: its row and its column bounds before clipping.
   always_comb begin
      span_row = ar_ff + i_s;
      span_lo  = ac_ff - i_s;
      span_hi  = ac_ff + i_s;
      case (cmd_ff)
         CMD_RECT: begin
            span_lo = ac_ff;
            span_hi = ac_ff + n_s - 12'sd1;
         end
         CMD_DOWN: begin
            span_row = ar_ff - i_s;
         end
         CMD_DIAMOND: begin
            // The lower half runs from the bottom tip back up towards the middle.
            if (phase_ff) begin
               span_row = ar_ff + n_s + n_s - i_s;
            end
         end
         default: begin
         end
      endcase
   end

   // Clip the span to the area in use; an empty result skips the span.
   assign lo_c    = (span_lo < 12'sd0) ? 12'sd0 : span_lo;
   assign hi_c    = (span_hi >= lim_cols) ? (lim_cols - 12'sd1) : span_hi;
   assign span_ok = (span_row >= 12'sd0) && (span_row < lim_rows) && (lo_c <= hi_c);

   always_comb begin
      st_in        = st_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      phase_in     = phase_ff;
      i_in         = i_ff;
      spans_in     = spans_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      cmd_in       = cmd_ff;
      ar_in        = ar_ff;
      ac_in        = ac_ff;
      brush_in     = brush_ff;
      ext_in       = ext_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      hi_in        = hi_ff;
      rd_ok_in     = rd_ok_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (st_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               st_in      = clr_rsp_ff ? ST_RESP : ST_IDLE;
               clr_rsp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload.command;
               ar_in    = $signed({4'b0000, req_payload.anchor_row});
               ac_in    = $signed({4'b0000, req_payload.anchor_col});
               brush_in = req_payload.brush;
               ext_in   = req_payload.extent;
               row_in   = $signed({4'b0000, req_payload.anchor_row});
               col_in   = $signed({4'b0000, req_payload.anchor_col});
               rd_ok_in = ($signed({4'b0000, req_payload.anchor_row}) < lim_rows) &&
                          ($signed({4'b0000, req_payload.anchor_col}) < lim_cols);
               res_in   = '0;
               phase_in = 1'b0;
               i_in     = '0;
               spans_in = {1'b0, req_payload.extent};
               case (req_payload.command)
                  CMD_RECT: begin
                     spans_in = {1'b0, req_payload.extent_rows};
                     st_in    = ST_SPAN;
                  end
                  CMD_UP, CMD_DOWN: begin
                     st_in = ST_SPAN;
                  end
                  CMD_DIAMOND: begin
                     // Upper half includes the middle row.
                     spans_in = {1'b0, req_payload.extent} + 9'd1;
                     st_in    = ST_SPAN;
                  end
                  CMD_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     st_in      = ST_CLEAR;
                  end
                  CMD_READ: begin
                     st_in = ST_READ;
                  end
                  default: begin
                     st_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SPAN: begin
            if (i_ff == spans_ff) begin
               if ((cmd_ff == CMD_DIAMOND) && !phase_ff) begin
                  phase_in = 1'b1;
                  i_in     = '0;
                  spans_in = {1'b0, ext_ff};
               end else begin
                  st_in = ST_RESP;
               end
            end else begin
               i_in = i_ff + 9'd1;
               if (span_ok) begin
                  row_in = span_row;
                  col_in = lo_c;
                  hi_in  = hi_c;
                  st_in  = ST_PIXEL;
               end
            end
         end
         ST_PIXEL: begin
            if (col_ff == hi_ff) begin
               st_in = ST_SPAN;
            end else begin
               col_in = col_ff + 12'sd1;
            end
         end
         ST_READ: begin
            st_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            res_in.read_data  = rd_ok_ff ? rd_data_ff : 8'd0;
            res_in.read_valid = rd_ok_ff;
            st_in             = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         phase_ff     <= 1'b0;
         i_ff         <= '0;
         spans_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= 8'd128;
         cols_ff      <= 8'd128;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         phase_ff     <= phase_in;
         i_ff         <= i_in;
         spans_ff     <= spans_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      ar_ff    <= ar_in;
      ac_ff    <= ac_in;
      brush_ff <= brush_in;
      ext_ff   <= ext_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      hi_ff    <= hi_in;
      rd_ok_ff <= rd_ok_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // One port: the clear sweep, a pixel write or a cell read, never two at once.
   always_comb begin
      if (st_ff == ST_CLEAR) begin
         mem_addr = clr_ff;
      end else begin
         mem_addr = ADDR_W'(row_ff[ROWI_W-1:0]) * ADDR_W'(MAX_COLS) +
                    ADDR_W'(col_ff[COLI_W-1:0]);
      end
   end

   assign mem_we    = (st_ff == ST_CLEAR) || (st_ff == ST_PIXEL);
   assign mem_re    = (st_ff == ST_READ) && rd_ok_ff;
   assign mem_wdata = (st_ff == ST_CLEAR) ? BLANK_CELL : brush_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= canvas_mem[mem_addr];
      end
   end

   `CSFC_ASSERT_NOW(a_pixel_in_area, clock, reset, st_ff == ST_PIXEL,
      (row_ff >= 12'sd0) && (row_ff < lim_rows) && (col_ff >= 12'sd0) && (col_ff < lim_cols))
   `CSFC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, st_ff != ST_IDLE)
   `CSFC_ASSERT_NOW(a_result_from_resp, clock, reset, $rose(rsp_valid_ff),
      $past(st_ff) == ST_RESP)
   `CSFC_ASSERT_NOW(a_invalid_read_zero, clock, reset,
      rsp_valid_ff && !rsp_ff.read_valid, rsp_ff.read_data == 8'd0)

endmodule

// File: test/clipped_shape_fill_canvas_test.sv
module clipped_shape_fill_canvas_test;
   import csfc_pkg::*;

   // Canvas geometry of the instance under test.
   localparam int CANVAS_ROWS = 128;
   localparam int CANVAS_COLS = 128;
   localparam int CANVAS_CELLS = CANVAS_ROWS * CANVAS_COLS;

   // The two command codes that the block must treat as no-ops.
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   // Length of the long receiver hold-off, in clock cycles.
   localparam int HOLD_CYCLES = 600;
   // A clear, a shape covering the whole canvas and the sweep after reset are the longest
   // quiet stretches, and this limit lies well above them.
   localparam int STALL_LIMIT = 200000;
   // A comfortable margin at the end of the run.
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASES = 6;
   localparam int CHUNK_ITEMS = 40;

   // Size settings per phase. The last phase draws a random setting instead.
   localparam logic [7:0] ROWS_PLAN [PHASES] = '{8'd128, 8'd255, 8'd0, 8'd1, 8'd200, 8'd77};
   localparam logic [7:0] COLS_PLAN [PHASES] = '{8'd128, 8'd255, 8'd0, 8'd255, 8'd1, 8'd93};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_ROWS;
   logic [7:0] csr_wdata = 8'd0;

   // Commands waiting for the driver, and replies the block still owes us.
   req_type queued_commands [$];
   rsp_type expected_replies [$];

   // Our own copy of the canvas and of the size registers.
   logic [7:0] canvas_model [CANVAS_CELLS];
   logic [7:0] rows_cfg = 8'd128;
   logic [7:0] cols_cfg = 8'd128;

   // Set by the monitor when the input item of the last edge was taken.
   logic req_taken = 1'b0;

   int commands_accepted = 0;
   int replies_checked = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   // Idle rates in percent, changed by the stimulus between phases.
   int send_idle_pct = 18;
   int stall_pct = 49;

   // The stimulus bumps hold_requests; the receiver serves each request once.
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;

   clipped_shape_fill_canvas #(
      .MAX_ROWS(CANVAS_ROWS),
      .MAX_COLS(CANVAS_COLS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Canvas prediction
   // ---------------------------------------------------------------------------------------

   // Sizes above the canvas act as the full canvas.
   function automatic int row_bound();
      return (int'(rows_cfg) > CANVAS_ROWS) ? CANVAS_ROWS : int'(rows_cfg);
   endfunction

   function automatic int col_bound();
      return (int'(cols_cfg) > CANVAS_COLS) ? CANVAS_COLS : int'(cols_cfg);
   endfunction

   // Pixels outside the rows and columns in use are simply dropped; nothing wraps.
   function automatic void plot(int r, int c, logic [7:0] brush);
      if (r >= 0 && r < row_bound() && c >= 0 && c < col_bound())
         canvas_model[r * CANVAS_COLS + c] = brush;
   endfunction

   // Fills columns c-half .. c+half of row r.
   function automatic void plot_span(int r, int c, int half, logic [7:0] brush);
      int j;
      for (j = -half; j <= half; j++)
         plot(r, c + j, brush);
   endfunction

   // Clear touches every cell, also those outside the area in use.
   function automatic void blank_canvas();
      int k;
      for (k = 0; k < CANVAS_CELLS; k++)
         canvas_model[k] = BLANK_CELL;
   endfunction

   // Applies one command to the model canvas and returns the reply it must produce.
   function automatic rsp_type paint_and_read(req_type item);
      rsp_type reply;
      int      r, c, rows, n, i, j;
      reply = '0;
      r = int'(item.anchor_row);
      c = int'(item.anchor_col);
      rows = int'(item.extent_rows);
      n = int'(item.extent);
      case (item.command)
         CMD_RECT: begin
            for (i = 0; i < rows; i++)
               for (j = 0; j < n; j++)
                  plot(r + i, c + j, item.brush);
         end
         CMD_UP: begin
            for (i = 0; i < n; i++)
               plot_span(r + i, c, i, item.brush);
         end
         CMD_DOWN: begin
            for (i = 0; i < n; i++)
               plot_span(r - i, c, i, item.brush);
         end
         CMD_DIAMOND: begin
            // The upper half widens down to row r+n, the lower half narrows to row r+2n.
            for (i = 0; i <= n; i++)
               plot_span(r + i, c, i, item.brush);
            for (i = 0; i < n; i++)
               plot_span(r + 2 * n - i, c, i, item.brush);
         end
         CMD_CLEAR: begin
            blank_canvas();
         end
         CMD_READ: begin
            if (r < row_bound() && c < col_bound()) begin
               reply.read_data = canvas_model[r * CANVAS_COLS + c];
               reply.read_valid = 1'b1;
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic req_type make_item(logic [2:0] cmd, logic [7:0] r, logic [7:0] c,
                                         logic [7:0] brush, logic [7:0] rows, logic [7:0] n);
      req_type item;
      item.command = cmd;
      item.anchor_row = r;
      item.anchor_col = c;
      item.brush = brush;
      item.extent_rows = rows;
      item.extent = n;
      return item;
   endfunction

   // Mostly reads and small shapes near the area in use, so that reads find painted cells.
   // A few items get one long side, and a very few cover most of the canvas, since those
   // cost one write per visible pixel.
   function automatic req_type random_item();
      int         pick;
      logic [2:0] cmd;
      logic [7:0] r, c, rows, n;
      pick = $urandom_range(199);
      r = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(135));
      c = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(135));
      rows = 8'($urandom_range(12));
      n = 8'($urandom_range(12));
      if (pick < 80)
         cmd = CMD_READ;
      else if (pick < 105)
         cmd = CMD_RECT;
      else if (pick < 130)
         cmd = CMD_UP;
      else if (pick < 155)
         cmd = CMD_DOWN;
      else if (pick < 190)
         cmd = CMD_DIAMOND;
      else if (pick < 192)
         cmd = CMD_CLEAR;
      else if (pick < 194)
         cmd = pick[0] ? CMD_SPARE_7 : CMD_SPARE_6;
      else
         cmd = CMD_READ;
      case ($urandom_range(49))
         0: begin
            rows = 8'($urandom_range(255));
            n = 8'($urandom_range(255));
         end
         1, 2, 3: rows = 8'($urandom_range(255));
         4, 5, 6: n = 8'($urandom_range(255));
         default: ;
      endcase
      return make_item(cmd, r, c, 8'($urandom_range(255)), rows, n);
   endfunction

   // Returns at a rising edge once every queued command has been taken and answered.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (queued_commands.size() != 0 || req_valid || commands_accepted != replies_checked);
   endtask

   // Writes both size registers while the block is idle.
   task automatic set_sizes(input logic [7:0] rows, input logic [7:0] cols);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows;
      @(negedge clock);
      csr_index <= CSR_COLS;
      csr_wdata <= cols;
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: offers the next queued command at the falling edge. A command stays on the
   // port until the monitor reports that it was taken, so a stalled item never changes.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= queued_commands.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus the long hold-off whenever one has been requested.
   always @(negedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: predicts each accepted command, checks each reply against the oldest
   // prediction, tracks register writes and watches for a hung block.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type wanted;
      rsp_type observed;
      logic    progress;
      if (reset) begin
         blank_canvas();
         rows_cfg = 8'd128;
         cols_cfg = 8'd128;
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         progress = 1'b0;
         if (csr_we) begin
            if (csr_index == CSR_ROWS)
               rows_cfg = csr_wdata;
            else
               cols_cfg = csr_wdata;
         end
         // Predict before checking, so that the reply order stays first in, first out.
         if (req_valid && !req_stall) begin
            expected_replies.push_back(paint_and_read(req_payload));
            commands_accepted <= commands_accepted + 1;
            progress = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            observed = rsp_payload;
            progress = 1'b1;
            if (expected_replies.size() == 0) begin
               mismatches++;
               if (mismatches < 50)
                  $display("%0t: reply with nothing expected: read_data %h read_valid %b",
                           $time, observed.read_data, observed.read_valid);
            end else begin
               wanted = expected_replies.pop_front();
               replies_checked <= replies_checked + 1;
               if (observed.read_data !== wanted.read_data) begin
                  mismatches++;
                  if (mismatches < 50)
                     $display("%0t: read_data expected %h actual %h",
                              $time, wanted.read_data, observed.read_data);
               end
               if (observed.read_valid !== wanted.read_valid) begin
                  mismatches++;
                  if (mismatches < 50)
                     $display("%0t: read_valid expected %b actual %b",
                              $time, wanted.read_valid, observed.read_valid);
               end
            end
         end
         req_taken <= req_valid && !req_stall;
         if (progress)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus: a directed set at the reset sizes, then six phases of random commands, each
   // behind a new size setting and the clear that a size change calls for.
   // ---------------------------------------------------------------------------------------
   initial begin
      int p;
      int k;
      int chunk;
      logic [7:0] rows_now, cols_now;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands. They queue up behind the clearing sweep that follows reset.
      queued_commands.push_back(make_item(CMD_READ, 0, 0, 8'hFF, 8'hFF, 8'hFF));
      queued_commands.push_back(make_item(CMD_RECT, 0, 0, "A", 3, 4));
      queued_commands.push_back(make_item(CMD_READ, 2, 3, 0, 0, 0));
      // Spans that run off the left edge and, for the down triangle, above row zero.
      queued_commands.push_back(make_item(CMD_UP, 10, 0, 8'hFF, 0, 5));
      queued_commands.push_back(make_item(CMD_DOWN, 3, 127, 8'h00, 0, 6));
      // A diamond of half distance zero writes its anchor pixel only.
      queued_commands.push_back(make_item(CMD_DIAMOND, 20, 20, "D", 0, 0));
      queued_commands.push_back(make_item(CMD_READ, 20, 20, 0, 0, 0));
      queued_commands.push_back(make_item(CMD_DIAMOND, 120, 126, "E", 0, 10));
      // Zero extents write nothing.
      queued_commands.push_back(make_item(CMD_RECT, 50, 50, "Z", 5, 0));
      queued_commands.push_back(make_item(CMD_RECT, 50, 50, "Z", 0, 5));
      queued_commands.push_back(make_item(CMD_UP, 50, 50, "Z", 9, 0));
      queued_commands.push_back(make_item(CMD_READ, 50, 50, 0, 0, 0));
      queued_commands.push_back(make_item(CMD_READ, 127, 127, 0, 0, 0));
      // Reads outside the area in use come back empty and not valid.
      queued_commands.push_back(make_item(CMD_READ, 128, 0, 0, 0, 0));
      queued_commands.push_back(make_item(CMD_READ, 255, 255, 0, 0, 0));
      queued_commands.push_back(make_item(CMD_SPARE_6, 255, 255, 8'hFF, 8'hFF, 8'hFF));
      queued_commands.push_back(make_item(CMD_SPARE_7, 1, 1, 8'hAA, 8'hAA, 8'hAA));
      // Large coordinates and largest extents, mostly or fully clipped away.
      queued_commands.push_back(make_item(CMD_RECT, 255, 255, 8'h55, 255, 255));
      queued_commands.push_back(make_item(CMD_RECT, 120, 0, "R", 8, 255));
      queued_commands.push_back(make_item(CMD_DOWN, 0, 64, "v", 0, 255));
      queued_commands.push_back(make_item(CMD_UP, 255, 0, "^", 0, 255));
      queued_commands.push_back(make_item(CMD_READ, 127, 100, 0, 0, 0));
      queued_commands.push_back(make_item(CMD_CLEAR, 0, 0, 0, 0, 0));
      queued_commands.push_back(make_item(CMD_READ, 2, 3, 0, 0, 0));
      wait_drained();

      for (p = 0; p < PHASES; p++) begin
         // Sender busy and receiver slow first, then the reverse, then flat out.
         if (p < 2) begin
            send_idle_pct = 18;
            stall_pct = 49;
         end else if (p < 4) begin
            send_idle_pct = 49;
            stall_pct = 18;
         end else begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         rows_now = (p == PHASES - 1) ? 8'($urandom_range(255)) : ROWS_PLAN[p];
         cols_now = (p == PHASES - 1) ? 8'($urandom_range(255)) : COLS_PLAN[p];
         set_sizes(rows_now, cols_now);
         queued_commands.push_back(make_item(CMD_CLEAR, 0, 0, 0, 0, 0));
         // Two chunks per phase; the sender rests between them until all replies are in.
         for (chunk = 0; chunk < 2; chunk++) begin
            for (k = 0; k < CHUNK_ITEMS; k++)
               queued_commands.push_back(random_item());
            // Once, hold the receiver off while commands keep coming, so the block fills.
            if (p == 1 && chunk == 1)
               hold_requests++;
            wait_drained();
         end
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected replies never arrived", $time, expected_replies.size());
      end
      $display("Ran %0d canvas commands (shapes, clears, reads, spare codes) under %0d size",
               commands_accepted, PHASES + 1);
      $display("settings with mixed stalls; %0d replies checked, %0d mismatches.",
               replies_checked, mismatches);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
